>>> hdl/tws_pkg.sv
// Shared types, byte codes and the head-byte judge of the whitespace sanitizer.
`default_nettype none

package tws_pkg;

  // Width of the running output length counter; it saturates at all ones
  localparam int LENGTH_BITS = 16;
  // Width of the length field carried on each result
  localparam int OUT_LEN_W   = 16;
  // Results one input request can cause at most
  localparam int MAX_RES     = 3;

  // Plain byte codes
  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  // UTF-8 lead and continuation bytes of the folded whitespace sequences
  localparam logic [7:0] U8_C2 = 8'hC2;
  localparam logic [7:0] U8_E1 = 8'hE1;
  localparam logic [7:0] U8_E2 = 8'hE2;
  localparam logic [7:0] U8_E3 = 8'hE3;
  localparam logic [7:0] U8_EF = 8'hEF;
  localparam logic [7:0] U8_80 = 8'h80;
  localparam logic [7:0] U8_81 = 8'h81;
  localparam logic [7:0] U8_8A = 8'h8A;
  localparam logic [7:0] U8_9A = 8'h9A;
  localparam logic [7:0] U8_9F = 8'h9F;
  localparam logic [7:0] U8_A0 = 8'hA0;
  localparam logic [7:0] U8_A8 = 8'hA8;
  localparam logic [7:0] U8_A9 = 8'hA9;
  localparam logic [7:0] U8_AF = 8'hAF;
  localparam logic [7:0] U8_BB = 8'hBB;
  localparam logic [7:0] U8_BF = 8'hBF;

  // One result as it leaves the block
  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 has_byte;
    logic                 end_of_string;
    logic                 run_last;
    logic [OUT_LEN_W-1:0] out_length;
  } res_t;

  // Verdict on a head byte: bytes consumed (zero ends the string) and the byte to emit
  typedef struct packed {
    logic [1:0] k;
    logic [7:0] ob;
  } judge_t;

  // Judge head byte c with lookahead n2, n3
  function automatic judge_t judge(input logic [7:0] c, input logic [7:0] n2,
                                   input logic [7:0] n3);
    judge_t j;
    logic   ws3;
    ws3  = 1'b0;
    j.k  = 2'd1;
    j.ob = BYTE_SPACE;
    unique case (c)
      U8_E1:   ws3 = (n2 == U8_9A) && (n3 == U8_80);
      U8_E2:   ws3 = ((n2 == U8_80) && (((n3 >= U8_80) && (n3 <= U8_8A)) ||
                       (n3 == U8_A8) || (n3 == U8_A9) || (n3 == U8_AF))) ||
                     ((n2 == U8_81) && (n3 == U8_9F));
      U8_E3:   ws3 = (n2 == U8_80) && (n3 == U8_80);
      U8_EF:   ws3 = (n2 == U8_BB) && (n3 == U8_BF);
      default: ws3 = 1'b0;
    endcase
    if (c == BYTE_NUL) begin
      j.k  = 2'd0;
      j.ob = BYTE_NUL;
    end else if ((c == U8_C2) && (n2 == U8_A0)) begin
      j.k = 2'd2;
    end else if (ws3) begin
      j.k = 2'd3;
    end else if (c == BYTE_CR) begin
      j.ob = BYTE_LF;
      j.k  = (n2 == BYTE_LF) ? 2'd2 : 2'd1;
    end else if ((c < BYTE_SPACE) && (c != BYTE_TAB) && (c != BYTE_LF)) begin
      j.k = 2'd1;
    end else begin
      j.ob = c;
    end
    return j;
  endfunction

endpackage

`default_nettype wire

>>> hdl/tws_in_reg.sv
// Input register stage: holds one accepted byte request until the core takes it.
`default_nettype none

module tws_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,   // in_last
  input  wire logic       free_i,
  output logic            valid_o,
  output logic [7:0]      byte_o,
  output logic            last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       fire;

  // Take a new request whenever the stage is empty or empties this cycle
  assign s_axis_tready = !valid_q || free_i;
  assign fire          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (fire) begin
      valid_d = 1'b1;
    end else if (free_i) begin
      valid_d = 1'b0;
    end
  end

  // Hold the control bit under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload on acceptance
  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

>>> hdl/tws_core.sv
// Sanitizer core: lookahead window state, head-byte judging and result building.
`default_nettype none

module tws_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      take_i,
  input  wire logic [7:0]                byte_i,
  input  wire logic                      last_i,
  output tws_pkg::res_t [tws_pkg::MAX_RES-1:0] res_o,
  output logic [1:0]                     n_o
);

  import tws_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  logic [7:0]             la_q [2];
  logic [7:0]             la_d [2];
  logic [1:0]             cnt_q, cnt_d;
  logic [LENGTH_BITS-1:0] wr_q, wr_d;
  logic                   disc_q, disc_d;

  logic [1:0]             cnt_c, cin, cb, cc;
  logic [7:0]             w0, w1, w2, b0, b1, b2, c0, c1, c2;
  judge_t                 ja, jb, jc;
  logic                   va, vb, vc;
  logic [LENGTH_BITS-1:0] l1, l2, l3;

  function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
    return (v == LEN_MAX) ? v : v + 1'b1;
  endfunction

  // Bytes left after consuming k of c held ones
  function automatic logic [1:0] left(input logic [1:0] c, input logic [1:0] k);
    return (k >= c) ? 2'd0 : c - k;
  endfunction

  // Build the window with the new byte in the first free slot
  always_comb begin
    cnt_c = cnt_q[1] ? 2'd2 : cnt_q;
    cin   = cnt_c + 2'd1;
    w0    = (cnt_c == 2'd0) ? byte_i : la_q[0];
    w1    = (cnt_c == 2'd1) ? byte_i : la_q[1];
    w2    = (cnt_c == 2'd2) ? byte_i : BYTE_NUL;
  end

  // Judge the head, then the heads left after each step
  always_comb begin
    ja = judge(w0, w1, w2);
    case (ja.k)
      2'd1:    {b0, b1, b2} = {w1, w2, BYTE_NUL};
      2'd2:    {b0, b1, b2} = {w2, BYTE_NUL, BYTE_NUL};
      default: {b0, b1, b2} = {BYTE_NUL, BYTE_NUL, BYTE_NUL};
    endcase
    cb = left(cin, ja.k);
    jb = judge(b0, b1, b2);
    case (jb.k)
      2'd1:    {c0, c1, c2} = {b1, b2, BYTE_NUL};
      2'd2:    {c0, c1, c2} = {b2, BYTE_NUL, BYTE_NUL};
      default: {c0, c1, c2} = {BYTE_NUL, BYTE_NUL, BYTE_NUL};
    endcase
    cc = left(cb, jb.k);
    jc = judge(c0, c1, c2);
    va = (ja.k != 2'd0);
    vb = va && (cb != 2'd0) && (jb.k != 2'd0);
    vc = vb && (cc != 2'd0) && (jc.k != 2'd0);
    l1 = len_inc(wr_q);
    l2 = len_inc(l1);
    l3 = len_inc(l2);
  end

  // Form results and the next window state
  always_comb begin
    res_o  = '0;
    n_o    = 2'd0;
    la_d   = la_q;
    cnt_d  = cnt_q;
    wr_d   = wr_q;
    disc_d = disc_q;
    if (take_i) begin
      if (disc_q) begin
        // Drop the tail of a string cut by a zero byte
        if (last_i) begin
          la_d   = '{BYTE_NUL, BYTE_NUL};
          cnt_d  = 2'd0;
          wr_d   = '0;
          disc_d = 1'b0;
        end
      end else if (last_i) begin
        // Drain the window at the end of the buffer
        if (!va) begin
          res_o[0] = '{out_byte: BYTE_NUL, has_byte: 1'b0, end_of_string: 1'b1,
                       run_last: 1'b1, out_length: OUT_LEN_W'(wr_q)};
          n_o      = 2'd1;
        end else begin
          res_o[0] = '{out_byte: ja.ob, has_byte: 1'b1, end_of_string: !vb,
                       run_last: !vb, out_length: OUT_LEN_W'(l1)};
          n_o      = 2'd1;
          if (vb) begin
            res_o[1] = '{out_byte: jb.ob, has_byte: 1'b1, end_of_string: !vc,
                         run_last: !vc, out_length: OUT_LEN_W'(l2)};
            n_o      = 2'd2;
          end
          if (vc) begin
            res_o[2] = '{out_byte: jc.ob, has_byte: 1'b1, end_of_string: 1'b1,
                         run_last: 1'b1, out_length: OUT_LEN_W'(l3)};
            n_o      = 2'd3;
          end
        end
        la_d   = '{BYTE_NUL, BYTE_NUL};
        cnt_d  = 2'd0;
        wr_d   = '0;
        disc_d = 1'b0;
      end else if (cin == 2'd3) begin
        if (!va) begin
          // Zero byte mid-buffer: end the string and discard up to the last byte
          res_o[0] = '{out_byte: BYTE_NUL, has_byte: 1'b0, end_of_string: 1'b1,
                       run_last: 1'b1, out_length: OUT_LEN_W'(wr_q)};
          n_o      = 2'd1;
          la_d     = '{BYTE_NUL, BYTE_NUL};
          cnt_d    = 2'd0;
          wr_d     = '0;
          disc_d   = 1'b1;
        end else begin
          res_o[0] = '{out_byte: ja.ob, has_byte: 1'b1, end_of_string: 1'b0,
                       run_last: 1'b1, out_length: OUT_LEN_W'(l1)};
          n_o      = 2'd1;
          la_d     = '{b0, b1};
          cnt_d    = 2'd3 - ja.k;
          wr_d     = l1;
        end
      end else begin
        // Warm-up: hold the byte
        la_d  = '{w0, w1};
        cnt_d = cin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q   <= '{BYTE_NUL, BYTE_NUL};
      cnt_q  <= 2'd0;
      wr_q   <= '0;
      disc_q <= 1'b0;
    end else begin
      la_q   <= la_d;
      cnt_q  <= cnt_d;
      wr_q   <= wr_d;
      disc_q <= disc_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tws_out_buf.sv
// Result register: holds up to three results of one request and shifts them out.
`default_nettype none

module tws_out_buf (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            load_i,
  input  wire tws_pkg::res_t [tws_pkg::MAX_RES-1:0] res_i,
  input  wire logic [1:0]                      n_i,
  output logic                                 free_o,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [23:0]                          m_axis_tdata,  // [7:0] out_byte, [23:8] out_length
  output logic [1:0]                           m_axis_tuser,  // [0] has_byte, [1] end_of_string
  output logic                                 m_axis_tlast   // run_last
);

  import tws_pkg::*;

  res_t [MAX_RES-1:0] res_q;
  logic [1:0]         cnt_q, cnt_d;
  logic               pop;

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  // Free when empty or when the final held result leaves this cycle
  assign free_o        = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = n_i;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Load a fresh set of results or advance the queue by one
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end else if (pop) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign m_axis_tdata = {res_q[0].out_length, res_q[0].out_byte};
  assign m_axis_tuser = {res_q[0].end_of_string, res_q[0].has_byte};
  assign m_axis_tlast = res_q[0].run_last;

endmodule

`default_nettype wire

>>> hdl/text_whitespace_sanitizer.sv
// Top level of the text whitespace sanitizer.
// Takes one text byte per cycle unless the output side holds it, and folds listed UTF-8
// whitespace sequences, disallowed control bytes and CR/CRLF into a space or LF,
// through a three-byte lookahead window. A byte request is accepted while the input
// register is empty or hands its request on, and passes that register, then the result
// register on its way out. The last byte of a buffer may cause up to three results,
// which leave the result register one per cycle while the output is ready, so that
// request holds the input side until the final one leaves. A zero byte ends the string
// with an empty end marker, and bytes up to the one marked last are then dropped. Each
// result carries the saturating count of bytes written so far in the string.
`default_nettype none

module text_whitespace_sanitizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,   // in_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] out_byte, [23:8] out_length
  output logic [1:0]       m_axis_tuser,   // [0] has_byte, [1] end_of_string
  output logic             m_axis_tlast    // run_last
);

  import tws_pkg::*;

  logic               free, s1_valid, s1_last, take;
  logic [7:0]         s1_byte;
  res_t [MAX_RES-1:0] res;
  logic [1:0]         res_n;

  // Move the held request into the core when the result register frees up
  assign take = s1_valid && free;

  tws_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .free_i        (free),
    .valid_o       (s1_valid),
    .byte_o        (s1_byte),
    .last_o        (s1_last)
  );

  tws_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (s1_byte),
    .last_i (s1_last),
    .res_o  (res),
    .n_o    (res_n)
  );

  tws_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take),
    .res_i         (res),
    .n_i           (res_n),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> hdl/tws_checker.sv
// Port-level checks on the sanitizer output stream, bound to the top level.
`default_nettype none

module tws_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // An empty end marker is a zero byte that ends both the string and the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tuser[1] && m_axis_tlast && (m_axis_tdata[7:0] == 8'h00))
    else $error("malformed end marker");

  // End of string is always the final result of its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("end of string without run end");

  // A data byte is never zero and never a carriage return
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[7:0] != 8'h00) && (m_axis_tdata[7:0] != 8'h0D))
    else $error("zero or CR byte emitted");

endmodule

bind text_whitespace_sanitizer tws_checker u_tws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
